/* src/p2w_pkg.sv */
// Shared types, widths and constants for the pixel-to-world point block.
// Depends on nothing; every other file of the block imports it.
package p2w_pkg;

    // Ground scale in Q16.16 metres per pixel, and the frame size limit.
    localparam int PIXEL_SCALE_Q16 = 328;
    localparam int MAX_DIM         = 4096;

    // Field widths.
    localparam int COORD_W  = 12;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int QUAT_W   = 16;
    localparam int POS_W    = 32;
    localparam int DIM_W    = 13;
    localparam int HALF_W   = DIM_W - 1;
    localparam int IN_W     = 2 * COORD_W + COLOR_W;
    localparam int OUT_W    = 2 * POS_W + COLOR_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Arithmetic widths.
    localparam int SCALE_W  = $clog2(PIXEL_SCALE_Q16 + 1) + 1;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int DX_W     = DIFF_W + SCALE_W;
    localparam int QPROD_W  = 2 * QUAT_W;
    localparam int MSUM_W   = QPROD_W + 4;
    localparam int MAT_W    = 32;
    localparam int MAT_FRAC = 28;
    localparam int PROD_W   = MAT_W + DX_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int RND_W    = SUM_W - MAT_FRAC;
    localparam int WSUM_W   = ((RND_W > POS_W) ? RND_W : POS_W) + 1;

    localparam int QUEUE_DEPTH = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W       = 4'd0,
        REG_QUAT_X       = 4'd1,
        REG_QUAT_Y       = 4'd2,
        REG_QUAT_Z       = 4'd3,
        REG_CAR_POS_X    = 4'd4,
        REG_CAR_POS_Y    = 4'd5,
        REG_FRAME_WIDTH  = 4'd6,
        REG_FRAME_HEIGHT = 4'd7
    } cfg_reg_t;

    // Settled configuration as the datapath sees it.
    typedef struct packed {
        logic signed [MAT_W-1:0]  m00;
        logic signed [MAT_W-1:0]  m01;
        logic signed [MAT_W-1:0]  m10;
        logic signed [MAT_W-1:0]  m11;
        logic signed [POS_W-1:0]  car_x;
        logic signed [POS_W-1:0]  car_y;
        logic        [HALF_W-1:0] half_w;
        logic        [HALF_W-1:0] half_h;
        logic                     quiet;
    } cfg_t;

    // One queued pixel: scaled offset and packed color.
    typedef struct packed {
        logic signed [DX_W-1:0]    dx;
        logic signed [DX_W-1:0]    ndy;
        logic        [COLOR_W-1:0] color;
    } item_t;

endpackage

/* src/p2w_cfg.sv */
// Configuration registers and the planar rotation matrix built from them.
// Depends on p2w_pkg.
module p2w_cfg
    import p2w_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam logic signed [MSUM_W-1:0] MAT_ONE = MSUM_W'(64'sd1 <<< MAT_FRAC);
    localparam logic signed [MSUM_W-1:0] MAT_LIM = MSUM_W'(64'sd1 <<< (MAT_FRAC + 2));
    localparam logic [DIM_W-1:0]         DIM_LIM = DIM_W'(MAX_DIM);

    logic signed [QUAT_W-1:0]  qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [POS_W-1:0]   car_x_reg, car_y_reg;
    logic        [DIM_W-1:0]   fw_reg, fh_reg;
    logic signed [QPROD_W-1:0] p_xx_reg, p_yy_reg, p_zz_reg, p_xy_reg, p_wz_reg;
    logic signed [MAT_W-1:0]   m00_reg, m01_reg, m10_reg, m11_reg;
    logic        [1:0]         settle_reg, settle_next;
    logic                      wr;
    logic signed [MSUM_W-1:0]  s00, s01, s10, s11;
    logic        [DIM_W-1:0]   fw_lim, fh_lim;

    function automatic logic signed [MAT_W-1:0] clamp_mat(input logic signed [MSUM_W-1:0] v);
        logic signed [MSUM_W-1:0] c;
        begin
            c = v;
            if (v > MAT_LIM)
            begin
                c = MAT_LIM;
            end
            else if (v < -MAT_LIM)
            begin
                c = -MAT_LIM;
            end
            clamp_mat = c[MAT_W-1:0];
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg    <= QUAT_W'(16384);
            qx_reg    <= '0;
            qy_reg    <= '0;
            qz_reg    <= '0;
            car_x_reg <= '0;
            car_y_reg <= '0;
            fw_reg    <= DIM_W'(640);
            fh_reg    <= DIM_W'(480);
        end
        else if (wr)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUAT_W:       qw_reg    <= cfg_data[QUAT_W-1:0];
                REG_QUAT_X:       qx_reg    <= cfg_data[QUAT_W-1:0];
                REG_QUAT_Y:       qy_reg    <= cfg_data[QUAT_W-1:0];
                REG_QUAT_Z:       qz_reg    <= cfg_data[QUAT_W-1:0];
                REG_CAR_POS_X:    car_x_reg <= cfg_data[POS_W-1:0];
                REG_CAR_POS_Y:    car_y_reg <= cfg_data[POS_W-1:0];
                REG_FRAME_WIDTH:  fw_reg    <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: fh_reg    <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Hold off new pixels until the matrix pipeline has caught up with a write.
    always_comb
    begin
        settle_next = settle_reg;
        if (wr)
        begin
            settle_next = 2'd3;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 2'd3;
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    // Quaternion products, one register stage.
    always_ff @(posedge clk)
    begin
        p_xx_reg <= qx_reg * qx_reg;
        p_yy_reg <= qy_reg * qy_reg;
        p_zz_reg <= qz_reg * qz_reg;
        p_xy_reg <= qx_reg * qy_reg;
        p_wz_reg <= qw_reg * qz_reg;
    end

    always_comb
    begin
        s00 = MAT_ONE - ((MSUM_W'(p_yy_reg) + MSUM_W'(p_zz_reg)) <<< 1);
        s01 = (MSUM_W'(p_xy_reg) - MSUM_W'(p_wz_reg)) <<< 1;
        s10 = (MSUM_W'(p_xy_reg) + MSUM_W'(p_wz_reg)) <<< 1;
        s11 = MAT_ONE - ((MSUM_W'(p_xx_reg) + MSUM_W'(p_zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        m00_reg <= clamp_mat(s00);
        m01_reg <= clamp_mat(s01);
        m10_reg <= clamp_mat(s10);
        m11_reg <= clamp_mat(s11);
    end

    assign fw_lim = (fw_reg > DIM_LIM) ? DIM_LIM : fw_reg;
    assign fh_lim = (fh_reg > DIM_LIM) ? DIM_LIM : fh_reg;

    always_comb
    begin
        cfg.m00    = m00_reg;
        cfg.m01    = m01_reg;
        cfg.m10    = m10_reg;
        cfg.m11    = m11_reg;
        cfg.car_x  = car_x_reg;
        cfg.car_y  = car_y_reg;
        cfg.half_w = fw_lim[DIM_W-1:1];
        cfg.half_h = fh_lim[DIM_W-1:1];
        cfg.quiet  = (settle_reg == 2'd0);
    end

endmodule

/* src/p2w_front.sv */
// Front end: accept pixels, drop any with a zero color channel, scale the centred offset.
// Depends on p2w_pkg.
module p2w_front
    import p2w_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  cfg_t            cfg,
    input  logic            q_full,
    output logic            q_push,
    output item_t           q_item
);

    localparam logic signed [SCALE_W-1:0] SCALE = SCALE_W'(PIXEL_SCALE_Q16);

    logic                      hold_v_reg;
    item_t                     hold_reg;
    logic        [COORD_W-1:0] col, row;
    logic        [CHAN_W-1:0]  blue, green, red;
    logic signed [DIFF_W-1:0]  dcol, drow;
    logic                      take, keep;

    assign col   = s_tdata[COORD_W-1:0];
    assign row   = s_tdata[2*COORD_W-1:COORD_W];
    assign blue  = s_tdata[2*COORD_W+CHAN_W-1:2*COORD_W];
    assign green = s_tdata[2*COORD_W+2*CHAN_W-1:2*COORD_W+CHAN_W];
    assign red   = s_tdata[2*COORD_W+3*CHAN_W-1:2*COORD_W+2*CHAN_W];

    assign dcol = $signed({1'b0, col}) - $signed({1'b0, cfg.half_w});
    assign drow = $signed({1'b0, cfg.half_h}) - $signed({1'b0, row});

    assign s_tready = cfg.quiet & (~hold_v_reg | ~q_full);
    assign take     = s_tvalid & s_tready;
    assign keep     = (blue != '0) & (green != '0) & (red != '0);
    assign q_push   = hold_v_reg & ~q_full;
    assign q_item   = hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_v_reg <= keep;
        end
        else if (q_push)
        begin
            hold_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg.dx    <= DX_W'(dcol) * DX_W'(SCALE);
            hold_reg.ndy   <= DX_W'(drow) * DX_W'(SCALE);
            hold_reg.color <= {red, green, blue};
        end
    end

endmodule

/* src/p2w_queue.sv */
// Short queue that decouples the front end from the rotation pipeline.
// Depends on p2w_pkg.
module p2w_queue
    import p2w_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        begin
            bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push & ~pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop & ~push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/p2w_back.sv */
// Back end: rotate the offset, round, add the car position, saturate.
// Depends on p2w_pkg.
module p2w_back
    import p2w_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  item_t            q_head,
    output logic             q_pop,
    input  cfg_t             cfg,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic signed [SUM_W-1:0]  HALF_LSB = SUM_W'(64'sd1 <<< (MAT_FRAC - 1));
    localparam logic signed [WSUM_W-1:0] POS_MAX  = WSUM_W'((64'sd1 <<< (POS_W - 1)) - 1);
    localparam logic signed [WSUM_W-1:0] POS_MIN  = -WSUM_W'(64'sd1 <<< (POS_W - 1));

    logic                      v1_reg, v2_reg, v3_reg;
    logic                      advance;
    logic signed [PROD_W-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic        [COLOR_W-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [RND_W-1:0]   rx_reg, ry_reg;
    logic signed [POS_W-1:0]   wx_reg, wy_reg;
    logic signed [SUM_W-1:0]   sx, sy;
    logic signed [WSUM_W-1:0]  tx, ty;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WSUM_W-1:0] v);
        logic signed [WSUM_W-1:0] c;
        begin
            c = v;
            if (v > POS_MAX)
            begin
                c = POS_MAX;
            end
            else if (v < POS_MIN)
            begin
                c = POS_MIN;
            end
            sat_pos = c[POS_W-1:0];
        end
    endfunction

    // The whole pipeline moves together unless the output is stalled.
    assign advance  = ~v3_reg | m_tready;
    assign q_pop    = advance & ~q_empty;
    assign m_tvalid = v3_reg;
    assign m_tdata  = {c3_reg, wy_reg, wx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= ~q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Sum the matrix products and round half up at the Q4.28 point.
    assign sx = SUM_W'(p00_reg) + SUM_W'(p01_reg) + HALF_LSB;
    assign sy = SUM_W'(p10_reg) + SUM_W'(p11_reg) + HALF_LSB;
    assign tx = WSUM_W'(rx_reg) + WSUM_W'(cfg.car_x);
    assign ty = WSUM_W'(ry_reg) + WSUM_W'(cfg.car_y);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p00_reg <= PROD_W'(cfg.m00) * PROD_W'(q_head.dx);
            p01_reg <= PROD_W'(cfg.m01) * PROD_W'(q_head.ndy);
            p10_reg <= PROD_W'(cfg.m10) * PROD_W'(q_head.dx);
            p11_reg <= PROD_W'(cfg.m11) * PROD_W'(q_head.ndy);
            c1_reg  <= q_head.color;
            rx_reg  <= RND_W'(sx >>> MAT_FRAC);
            ry_reg  <= RND_W'(sy >>> MAT_FRAC);
            c2_reg  <= c1_reg;
            wx_reg  <= sat_pos(tx);
            wy_reg  <= sat_pos(ty);
            c3_reg  <= c2_reg;
        end
    end

endmodule

/* src/pixel_to_world_point.sv */
// Top level of the pixel-to-world point block.
// Depends on p2w_pkg, p2w_cfg, p2w_front, p2w_queue and p2w_back.
//
// Maps one bird's-eye pixel per clock, unless the block stalls, to a ground
// point in world coordinates. A pixel with any color channel at zero is
// accepted and dropped; every other pixel yields one item holding world x and
// y (Q16.16 metres, saturated) and the packed color. The front end takes a
// pixel every cycle while settled and not held up by a full queue, centres and
// scales it and parks it in a four-entry queue; the back end rotates it by the
// planar part of the quaternion matrix, rounds, adds the car position and
// saturates in three register stages that advance together and stall only on
// output backpressure. Sustained rate is one pixel per clock while the output
// is not stalled. Configuration writes are always taken; after a write, and
// after reset, the input stays not ready while the rotation matrix is rebuilt
// from the quaternion in a two-stage multiply and clamp. Write configuration
// only while the block is idle.
module pixel_to_world_point
    import p2w_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel input: pixel_col[11:0], pixel_row[23:12], blue[31:24],
    // green[39:32], red[47:40]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    // result output: world_x[31:0], world_y[63:32], color_rgb[87:64]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    logic  q_push, q_pop, q_empty, q_full;
    item_t q_in, q_head;

    // Register file and rotation matrix.
    p2w_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Accept, drop pixels with a zero color channel, scale the offset.
    p2w_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    // Decouple the two halves.
    p2w_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Rotate, translate, saturate, and hold the result for the consumer.
    p2w_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
